/* rtl/tgp_pkg.sv */
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types, command codes and helpers for the turtle grid plotter.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int MAX_SIDE      = 64;
  localparam int COORD_W       = 6;
  localparam int BITS_W        = 64;
  localparam int KIND_W        = 3;
  localparam int DIST_W        = 6;

  // command kinds
  localparam logic [KIND_W-1:0] K_PEN_UP   = 3'd0;
  localparam logic [KIND_W-1:0] K_PEN_DOWN = 3'd1;
  localparam logic [KIND_W-1:0] K_TURN_R   = 3'd2;
  localparam logic [KIND_W-1:0] K_TURN_L   = 3'd3;
  localparam logic [KIND_W-1:0] K_MOVE     = 3'd4;
  localparam logic [KIND_W-1:0] K_DUMP     = 3'd5;

  // headings
  localparam logic [1:0] H_RIGHT = 2'd0;
  localparam logic [1:0] H_DOWN  = 2'd1;
  localparam logic [1:0] H_LEFT  = 2'd2;
  localparam logic [1:0] H_UP    = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [BITS_W-1:0]  row_bits_t;

  // grid access for one cycle: a read and a write, each with its own row
  typedef struct packed {
    logic      rd;
    coord_t    rd_row;
    logic      wr;
    coord_t    wr_row;
    row_bits_t wr_bits;
  } grid_req_t;

  // ones in bits below n, all ones from n = 64 up
  function automatic row_bits_t lowmask(input logic [COORD_W:0] n);
    row_bits_t m;
    if (n >= 7'(BITS_W)) begin
      m = '1;
    end else begin
      m = (row_bits_t'(1) << n[COORD_W-1:0]) - row_bits_t'(1);
    end
    return m;
  endfunction

endpackage

/* rtl/tgp_grid.sv */
// ----------------------------------------------------------------------------
// tgp_grid
// Grid row store: one read and one write port, registered read data, and a
// per-row valid flag so that rows not yet written read back as zero.
// ----------------------------------------------------------------------------
module tgp_grid #(
  parameter int DEPTH = tgp_pkg::MAX_SIDE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tgp_pkg::grid_req_t  req,
  output tgp_pkg::row_bits_t  rd_data
);
  import tgp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  row_bits_t        mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  row_bits_t        q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem_r[req.wr_row[AW-1:0]] <= req.wr_bits;
    end
    if (req.rd) begin
      q_r <= mem_r[req.rd_row[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.wr) begin
        vld_r[req.wr_row[AW-1:0]] <= 1'b1;
      end
      if (req.rd) begin
        q_vld_r <= vld_r[req.rd_row[AW-1:0]];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

/* rtl/turtle_grid_plotter.sv */
// ----------------------------------------------------------------------------
// turtle_grid_plotter
// Turtle plotter on a square bit grid: pen, heading and position commands,
// line drawing into a row store and a row-by-row dump of the grid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | in_kind, in_distance
//  out_    | output    | out_valid/out_stall| out_row_index, out_row_bits,
//          |           |                    | out_last
//
//  pen, turn and unused commands are handled in the idle state. a pen-down
//  move walks the row store one row per cycle through a read-modify-write
//  pipe (a horizontal move is one row). a dump reads one row per cycle when
//  out_stall stays low. in_stall is high while a pen-down move of nonzero
//  distance or a dump is in progress; out_stall only slows the dump. the
//  grid reads as cleared right after reset.
// ----------------------------------------------------------------------------
module turtle_grid_plotter #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tgp_pkg::KIND_W-1:0]         in_kind,
  input  logic [tgp_pkg::DIST_W-1:0]         in_distance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tgp_pkg::COORD_W-1:0]        out_row_index,
  output logic [tgp_pkg::BITS_W-1:0]         out_row_bits,
  output logic                               out_last
);
  import tgp_pkg::*;

  localparam int SIDE = (GRID_SIZE < MAX_SIDE) ? GRID_SIZE : MAX_SIDE;
  localparam logic [COORD_W:0] SIDE_N  = (COORD_W+1)'(SIDE);
  localparam logic [COORD_W:0] SIDE_M1 = (COORD_W+1)'(SIDE - 1);
  localparam row_bits_t        SIDE_MASK = lowmask(SIDE_N);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             pen_r, pen_nxt;
  logic [1:0]       head_r, head_nxt;
  coord_t           row_r, row_nxt;
  coord_t           col_r, col_nxt;

  coord_t           walk_row_r, walk_row_nxt;
  logic [COORD_W:0] walk_cnt_r, walk_cnt_nxt;
  logic             walk_up_r, walk_up_nxt;
  row_bits_t        mask_r, mask_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  coord_t           wr_row_r, wr_row_nxt;

  logic [COORD_W:0] dump_iss_r, dump_iss_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  coord_t           pend_row_r, pend_row_nxt;

  logic             out_valid_r, out_valid_nxt;
  coord_t           out_idx_r, out_idx_nxt;
  row_bits_t        out_bits_r, out_bits_nxt;
  logic             out_last_r, out_last_nxt;

  grid_req_t        greq;
  row_bits_t        grd;

  logic             accept, walk_issue, dump_issue, dump_load;
  logic [COORD_W:0] dist7, row7, col7, sum_r7, sum_c7, room, lo7;
  coord_t           down_row, up_row, right_col, left_col;
  logic [COORD_W:0] cnt_down, cnt_up;
  row_bits_t        mask_right, mask_left, mask_vert;

  tgp_grid #(.DEPTH(SIDE)) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (greq),
    .rd_data (grd)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // move arithmetic, all from the current position
  always_comb begin
    dist7  = {1'b0, in_distance};
    row7   = {1'b0, row_r};
    col7   = {1'b0, col_r};
    sum_r7 = row7 + dist7;
    sum_c7 = col7 + dist7;
    down_row  = (sum_r7 > SIDE_M1) ? SIDE_M1[COORD_W-1:0] : sum_r7[COORD_W-1:0];
    right_col = (sum_c7 > SIDE_M1) ? SIDE_M1[COORD_W-1:0] : sum_c7[COORD_W-1:0];
    up_row    = (dist7 > row7) ? '0 : row_r - in_distance;
    left_col  = (dist7 > col7) ? '0 : col_r - in_distance;
    room      = SIDE_N - row7;
    cnt_down  = (dist7 < room) ? dist7 : room;
    cnt_up    = (dist7 < row7 + 7'd1) ? dist7 : row7 + 7'd1;
    lo7       = (dist7 > col7) ? '0 : col7 + 7'd1 - dist7;
    mask_right = lowmask(sum_c7) & ~lowmask(col7) & SIDE_MASK;
    mask_left  = lowmask(col7 + 7'd1) & ~lowmask(lo7);
    mask_vert  = row_bits_t'(1) << col_r;
  end

  assign walk_issue = (state_r == S_WALK) && (walk_cnt_r != '0);
  assign dump_load  = rd_pend_r && (!out_valid_r || !out_stall);
  assign dump_issue = (state_r == S_DUMP) && (dump_iss_r < SIDE_N) &&
                      (!rd_pend_r || dump_load);

  always_comb begin
    greq.rd      = walk_issue || dump_issue;
    greq.rd_row  = (state_r == S_DUMP) ? dump_iss_r[COORD_W-1:0] : walk_row_r;
    greq.wr      = wr_pend_r;
    greq.wr_row  = wr_row_r;
    greq.wr_bits = grd | mask_r;
  end

  always_comb begin
    state_nxt    = state_r;
    pen_nxt      = pen_r;
    head_nxt     = head_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    walk_row_nxt = walk_row_r;
    walk_cnt_nxt = walk_cnt_r;
    walk_up_nxt  = walk_up_r;
    mask_nxt     = mask_r;
    wr_pend_nxt  = walk_issue;
    wr_row_nxt   = walk_row_r;
    dump_iss_nxt = dump_iss_r;
    rd_pend_nxt  = rd_pend_r;
    pend_row_nxt = pend_row_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            K_PEN_UP:   pen_nxt  = 1'b0;
            K_PEN_DOWN: pen_nxt  = 1'b1;
            K_TURN_R:   head_nxt = head_r + 2'd1;
            K_TURN_L:   head_nxt = head_r + 2'd3;
            K_MOVE: begin
              walk_row_nxt = row_r;
              walk_up_nxt  = (head_r == H_UP);
              case (head_r)
                H_RIGHT: begin
                  col_nxt      = right_col;
                  walk_cnt_nxt = (in_distance != '0) ? 7'd1 : 7'd0;
                  mask_nxt     = mask_right;
                end
                H_DOWN: begin
                  row_nxt      = down_row;
                  walk_cnt_nxt = cnt_down;
                  mask_nxt     = mask_vert;
                end
                H_LEFT: begin
                  col_nxt      = left_col;
                  walk_cnt_nxt = (in_distance != '0) ? 7'd1 : 7'd0;
                  mask_nxt     = mask_left;
                end
                default: begin
                  row_nxt      = up_row;
                  walk_cnt_nxt = cnt_up;
                  mask_nxt     = mask_vert;
                end
              endcase
              // pen up or zero distance: position moves, nothing drawn
              if (pen_r && in_distance != '0) begin
                state_nxt = S_WALK;
              end
            end
            K_DUMP: begin
              dump_iss_nxt = '0;
              state_nxt    = S_DUMP;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_issue) begin
          walk_cnt_nxt = walk_cnt_r - 7'd1;
          walk_row_nxt = walk_up_r ? walk_row_r - 6'd1 : walk_row_r + 6'd1;
        end else if (!wr_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (dump_issue) begin
          dump_iss_nxt = dump_iss_r + 7'd1;
          pend_row_nxt = dump_iss_r[COORD_W-1:0];
          rd_pend_nxt  = 1'b1;
        end else if (dump_load) begin
          rd_pend_nxt = 1'b0;
        end
        if (dump_iss_r == SIDE_N && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register, refilled from the read pipe
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    if (dump_load) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = pend_row_r;
      out_bits_nxt  = grd;
      out_last_nxt  = ({1'b0, pend_row_r} == SIDE_M1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pen_r       <= 1'b1;
      head_r      <= H_RIGHT;
      row_r       <= '0;
      col_r       <= '0;
      walk_cnt_r  <= '0;
      wr_pend_r   <= 1'b0;
      dump_iss_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_r       <= pen_nxt;
      head_r      <= head_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      dump_iss_r  <= dump_iss_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_row_r <= walk_row_nxt;
    walk_up_r  <= walk_up_nxt;
    mask_r     <= mask_nxt;
    wr_row_r   <= wr_row_nxt;
    pend_row_r <= pend_row_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_idx_r;
  assign out_row_bits  = out_bits_r;
  assign out_last      = out_last_r;

endmodule

/* rtl/tgp_checker.sv */
// ----------------------------------------------------------------------------
// tgp_checker
// Port-level checks for the turtle grid plotter, bound to the top level.
// ----------------------------------------------------------------------------
module tgp_checker #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [tgp_pkg::KIND_W-1:0]  in_kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tgp_pkg::COORD_W-1:0] out_row_index,
  input logic [tgp_pkg::BITS_W-1:0]  out_row_bits,
  input logic                        out_last
);
  import tgp_pkg::*;

  localparam int SIDE = (GRID_SIZE < MAX_SIDE) ? GRID_SIZE : MAX_SIDE;
  localparam logic [COORD_W:0] SIDE_N  = (COORD_W+1)'(SIDE);
  localparam logic [COORD_W:0] SIDE_M1 = (COORD_W+1)'(SIDE - 1);
  localparam row_bits_t        SIDE_MASK = lowmask(SIDE_N);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_index) &&
    $stable(out_row_bits) && $stable(out_last))
    else $error("stalled result changed");

  // last flag marks exactly the final grid row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == ({1'b0, out_row_index} == SIDE_M1)))
    else $error("last flag on wrong row");

  // no marks outside the grid
  a_row_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_row_bits & ~SIDE_MASK) == '0))
    else $error("row bits beyond grid edge");

  // a dump request keeps the input side busy
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == K_DUMP |=> in_stall)
    else $error("request taken during dump");

  // rows come out in order within a dump
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid |->
    {1'b0, out_row_index} == {1'b0, $past(out_row_index)} + 7'd1)
    else $error("dump rows out of order");

endmodule

bind turtle_grid_plotter tgp_checker #(.GRID_SIZE(GRID_SIZE)) u_tgp_checker (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the turtle grid plotter. A directed table covers the command
// set, clipping at the right and top grid edges, pen-up moves and the unused
// kinds. A random command stream follows under four sender/receiver idle
// mixes. Every dumped row is compared against a behavioral model of the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tgp_pkg::*;

  localparam int GRID_SIZE = GRID_SIZE_DEF;
  localparam int SIDE      = (GRID_SIZE < MAX_SIDE) ? GRID_SIZE : MAX_SIDE;
  localparam row_bits_t SIDE_MASK =
    (SIDE >= BITS_W) ? {BITS_W{1'b1}} : ((row_bits_t'(1) << SIDE) - row_bits_t'(1));

  // kinds the block leaves alone
  localparam logic [KIND_W-1:0] K_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_B = 3'd7;

  localparam int RANDOM_PER_PHASE = 50;

  typedef struct {
    coord_t    idx;
    row_bits_t bits;
    logic      last;
  } grid_row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIST_W-1:0] steps;
    logic              clear_dump;
  } plot_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [DIST_W-1:0] in_distance = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  coord_t            out_row_index;
  row_bits_t         out_row_bits;
  logic              out_last;

  // model of the plotter state
  row_bits_t   plot_grid [MAX_SIDE] = '{default: '0};
  logic        pen_down = 1'b1;
  logic [1:0]  heading = H_RIGHT;
  coord_t      cur_row = '0;
  coord_t      cur_col = '0;
  grid_row_t   pending_rows [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int fail_count         = 0;
  int commands_sent      = 0;
  int dumps_sent         = 0;
  int rows_checked       = 0;

  // directed sweep: clipping on the right and top edges, heading wrap both
  // ways, pen-up travel, zero distance and the unused kinds
  plot_cmd_t directed_cmds [25] = '{
    '{K_DUMP,     6'd0,  1'b1},  // grid reads clear after reset
    '{K_SPARE_A,  6'd63, 1'b0},
    '{K_SPARE_B,  6'd42, 1'b0},
    '{K_MOVE,     6'd0,  1'b0},
    '{K_MOVE,     6'd63, 1'b0},  // row to the right edge, stops there
    '{K_MOVE,     6'd5,  1'b0},  // marks clip past the right edge
    '{K_TURN_R,   6'd0,  1'b0},
    '{K_MOVE,     6'd10, 1'b0},
    '{K_TURN_R,   6'd0,  1'b0},
    '{K_MOVE,     6'd63, 1'b0},  // reaches column zero
    '{K_TURN_R,   6'd0,  1'b0},
    '{K_MOVE,     6'd63, 1'b0},  // upward line, saturates at row zero
    '{K_TURN_R,   6'd0,  1'b0},  // heading wraps to right
    '{K_PEN_UP,   6'd21, 1'b0},
    '{K_MOVE,     6'd20, 1'b0},
    '{K_TURN_L,   6'd0,  1'b0},  // heading wraps to up
    '{K_TURN_L,   6'd0,  1'b0},
    '{K_TURN_L,   6'd0,  1'b0},
    '{K_MOVE,     6'd30, 1'b0},  // pen-up move down
    '{K_PEN_DOWN, 6'd0,  1'b0},
    '{K_MOVE,     6'd1,  1'b0},
    '{K_TURN_L,   6'd0,  1'b0},
    '{K_MOVE,     6'd42, 1'b0},
    '{K_DUMP,     6'd63, 1'b0},
    '{K_TURN_R,   6'd63, 1'b0}
  };

  int phase_sender_pct   [4] = '{0, 60, 0, 32};
  int phase_receiver_pct [4] = '{0, 0, 60, 32};

  turtle_grid_plotter #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_distance  (in_distance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_row_bits (out_row_bits),
    .out_last     (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic coord_t saturate(input int v);
    if (v < 0) return '0;
    if (v > SIDE - 1) return coord_t'(SIDE - 1);
    return coord_t'(v);
  endfunction

  // advance the model by one command and queue the rows it dumps
  function automatic void plot_command(input logic [KIND_W-1:0] kind,
                                       input logic [DIST_W-1:0] steps);
    int dr;
    int dc;
    int r;
    int c;
    int i;
    dr = 0;
    dc = 0;
    case (kind)
      K_PEN_UP: begin
        pen_down = 1'b0;
      end
      K_PEN_DOWN: begin
        pen_down = 1'b1;
      end
      K_TURN_R: begin
        heading = heading + 2'd1;
      end
      K_TURN_L: begin
        heading = heading - 2'd1;
      end
      K_MOVE: begin
        case (heading)
          H_RIGHT: dc = 1;
          H_DOWN:  dr = 1;
          H_LEFT:  dc = -1;
          default: dr = -1;
        endcase
        if (pen_down) begin
          for (i = 0; i < int'(steps); i++) begin
            r = int'(cur_row) + dr * i;
            c = int'(cur_col) + dc * i;
            if (r < 0 || r >= SIDE || c < 0 || c >= SIDE) break;
            plot_grid[r][c] = 1'b1;
          end
        end
        cur_row = saturate(int'(cur_row) + dr * int'(steps));
        cur_col = saturate(int'(cur_col) + dc * int'(steps));
      end
      K_DUMP: begin
        for (r = 0; r < SIDE; r++) begin
          pending_rows.push_back('{coord_t'(r), plot_grid[r] & SIDE_MASK, r == SIDE - 1});
        end
      end
      default: begin
      end
    endcase
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DIST_W-1:0] steps,
                              input logic clear_dump);
    int r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid    <= 1'b0;
      in_kind     <= KIND_W'($urandom);
      in_distance <= DIST_W'($urandom);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_distance <= steps;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    if (kind == K_DUMP) dumps_sent++;
    if (clear_dump) begin
      for (r = 0; r < SIDE; r++) begin
        pending_rows.push_back('{coord_t'(r), row_bits_t'(0), r == SIDE - 1});
      end
    end else begin
      plot_command(kind, steps);
    end
  endtask

  // sender holds off until every queued row is back, then lets a move finish
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SIDE + 8) @(posedge clk);
  endtask

  task automatic pick_command(output logic [KIND_W-1:0] kind,
                              output logic [DIST_W-1:0] steps);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)       kind = ($urandom_range(0, 1) != 0) ? K_SPARE_A : K_SPARE_B;
    else if (roll < 10) kind = K_DUMP;
    else if (roll < 18) kind = K_PEN_UP;
    else if (roll < 30) kind = K_PEN_DOWN;
    else if (roll < 42) kind = K_TURN_R;
    else if (roll < 54) kind = K_TURN_L;
    else                kind = K_MOVE;
    // mostly short strokes so the turtle wanders inside the grid
    steps = ($urandom_range(0, 3) == 0) ? DIST_W'($urandom_range(0, 63))
                                        : DIST_W'($urandom_range(0, 12));
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    grid_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row %0d with no dump pending", out_row_index);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_row_index !== want.idx) begin
          $error("row_index: expected %0d, got %0d", want.idx, out_row_index);
          fail_count++;
        end
        if (out_row_bits !== want.bits) begin
          $error("row_bits: expected %h, got %h", want.bits, out_row_bits);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [DIST_W-1:0] steps;
    int ph;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_cmds[i]) begin
      send_request(directed_cmds[i].kind, directed_cmds[i].steps, directed_cmds[i].clear_dump);
    end
    wait_for_drain();

    for (ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = phase_sender_pct[ph];
      receiver_stall_pct = phase_receiver_pct[ph];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_command(kind, steps);
        send_request(kind, steps, 1'b0);
      end
      send_request(K_DUMP, DIST_W'($urandom), 1'b0);
      wait_for_drain();
    end

    $display("ran %0d commands with %0d grid dumps, %0d rows compared", commands_sent,
             dumps_sent, rows_checked);
    $display("idle mixes: none, sender 60%%, receiver 60%%, both 32%%");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d rows outstanding", pending_rows.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
